[sv/quant_block_dequant_dot_unit_defines.svh]
// Assertion macros shared by the dequantize/dot unit.
`ifndef QUANT_BLOCK_DEQUANT_DOT_UNIT_DEFINES_SVH
`define QUANT_BLOCK_DEQUANT_DOT_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define QDD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define QDD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/qdd_pkg.sv]
// Types, constants and float helpers of the dequantize/dot unit.
`timescale 1ns / 1ps
package qdd_pkg;

  // Activation store depth, a power of two.
  localparam int MaxCols    = 4096;
  localparam int ColW       = $clog2(MaxCols);
  localparam int QueueDepth = 4;

  localparam logic       ActStore     = 1'b0;
  localparam logic [7:0] CfgQuantType = 8'd0;
  localparam logic [7:0] CfgMode      = 8'd1;
  localparam logic [7:0] CfgBlocks    = 8'd2;
  localparam logic [7:0] CfgFormat    = 8'd3;
  localparam logic [1:0] FmtFp16      = 2'd1;
  localparam logic [1:0] FmtBf16      = 2'd2;

  typedef enum logic [1:0] {OP_ACT, OP_WEIGHT, OP_SUM} op_kind_e;
  typedef enum logic [1:0] {SP_NUM, SP_NAN, SP_INF} spec_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [ColW-1:0]  col;
    logic [31:0]      data;
    logic [7:0]       q;
    logic [15:0]      scale;
    logic             emit;
    logic             last;
    logic             rowend;
  } op_t;

  // Unrounded float: leading one of man at bit 47 means biased exponent exp.
  typedef struct packed {
    logic               sgn;
    logic signed [12:0] exp;
    logic [47:0]        man;
    spec_e              spec;
  } pre_t;

  function automatic logic [31:0] half_to_f32(logic [15:0] h);
    logic [3:0]  p;
    logic [22:0] frac;
    logic [31:0] r;
    p = '0;
    if (h[14:10] == 5'd0) begin
      for (int i = 0; i < 10; i++) if (h[i]) p = 4'(i);
      frac = {13'b0, h[9:0]} << (5'd23 - 5'(p));
      r = (h[9:0] == 10'd0) ? {h[15], 31'b0} : {h[15], 8'(p) + 8'd103, frac};
    end else if (h[14:10] == 5'h1F) begin
      r = {h[15], 8'hFF, h[9:0], 13'b0};
    end else begin
      r = {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] i8_to_f32(logic [7:0] q);
    logic [7:0]  mag;
    logic [2:0]  p;
    logic [22:0] frac;
    mag = q[7] ? 8'(-q) : q;
    p = '0;
    for (int i = 0; i < 8; i++) if (mag[i]) p = 3'(i);
    frac = {15'b0, mag} << (5'd23 - 5'(p));
    return (mag == 8'd0) ? 32'd0 : {q[7], 8'd127 + 8'(p), frac};
  endfunction

  function automatic logic [31:0] decode_act(logic [31:0] bits, logic [1:0] fmt);
    logic [31:0] r;
    case (fmt)
      FmtFp16: r = half_to_f32(bits[15:0]);
      FmtBf16: r = {bits[15:0], 16'b0};
      default: r = bits;
    endcase
    return r;
  endfunction

  function automatic pre_t fp_mul_pre(logic [31:0] a, logic [31:0] b);
    logic [7:0]  ea, eb;
    logic        na, nb, ia, ib, za, zb;
    pre_t        r;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ia = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    ib = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    za = a[30:0] == 31'd0;
    zb = b[30:0] == 31'd0;
    r.sgn = a[31] ^ b[31];
    r.man = {24'b0, (a[30:23] != 8'd0), a[22:0]} * {24'b0, (b[30:23] != 8'd0), b[22:0]};
    r.exp = $signed({5'b0, ea}) + $signed({5'b0, eb}) - 13'sd126;
    if (na || nb || (ia && zb) || (ib && za)) r.spec = SP_NAN;
    else if (ia || ib)                        r.spec = SP_INF;
    else                                      r.spec = SP_NUM;
    return r;
  endfunction

  function automatic pre_t fp_add_pre(logic [31:0] a, logic [31:0] b);
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [47:0] big, sf, sm;
    logic        st, nx, ny, ix, iy;
    pre_t        r;
    if (a[30:0] < b[30:0]) begin
      x = b; y = a;
    end else begin
      x = a; y = b;
    end
    ex  = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey  = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d   = ex - ey;
    big = {1'b0, (x[30:23] != 8'd0), x[22:0], 23'b0};
    sf  = {1'b0, (y[30:23] != 8'd0), y[22:0], 23'b0};
    if (d >= 8'd48) begin
      sm = '0;
      st = |sf;
    end else begin
      sm = sf >> d;
      st = |(sf << (8'd48 - d));
    end
    sm[0] = sm[0] | st;
    r.man = (x[31] == y[31]) ? big + sm : big - sm;
    r.exp = $signed({5'b0, ex}) + 13'sd1;
    r.sgn = (r.man == 48'd0) ? (x[31] & y[31]) : x[31];
    nx = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    ny = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    ix = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    iy = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    if (nx || ny || (ix && iy && (x[31] != y[31]))) r.spec = SP_NAN;
    else if (ix)                                    r.spec = SP_INF;
    else                                            r.spec = SP_NUM;
    return r;
  endfunction

  // Bring the leading one to bit 47.
  function automatic pre_t fp_norm(pre_t p);
    logic [5:0] lz;
    pre_t       r;
    lz = '0;
    for (int i = 0; i < 48; i++) if (p.man[i]) lz = 6'(47 - i);
    r      = p;
    r.man  = p.man << lz;
    r.exp  = p.exp - $signed({7'b0, lz});
    return r;
  endfunction

  // Round to nearest even, with gradual underflow and overflow to infinity.
  // An exact zero wins over the exponent, which may sit high after cancellation.
  function automatic logic [31:0] fp_round(pre_t p);
    logic signed [12:0] sh;
    logic [47:0]        ms;
    logic               st, g;
    logic [7:0]         er;
    logic [23:0]        mant;
    logic [24:0]        rnd;
    logic [31:0]        pk, r;
    ms = p.man; st = 1'b0; er = 8'd0; sh = '0;
    if (p.exp <= 13'sd0) begin
      sh = 13'sd1 - p.exp;
      if (sh >= 13'sd48) begin
        ms = '0;
        st = |p.man;
      end else begin
        ms = p.man >> sh[5:0];
        st = |(p.man << (6'd48 - sh[5:0]));
      end
    end else begin
      er = p.exp[7:0];
    end
    mant = ms[47:24];
    g    = ms[23];
    st   = st | (|ms[22:0]);
    rnd  = {1'b0, mant} + 25'(g & (st | mant[0]));
    pk   = (er == 8'd0) ? 32'(rnd) : {1'b0, er - 8'd1, 23'b0} + 32'(rnd);
    if (p.spec == SP_NAN)           r = 32'h7FC0_0000;
    else if (p.spec == SP_INF)      r = {p.sgn, 8'hFF, 23'b0};
    else if (p.man == 48'd0)        r = {p.sgn, 31'b0};
    else if (p.exp >= 13'sd255)     r = {p.sgn, 8'hFF, 23'b0};
    else                            r = {p.sgn, pk[30:0]};
    return r;
  endfunction

  function automatic logic [15:0] f32_to_half(logic [31:0] u);
    logic [30:0] a;
    logic [7:0]  e;
    logic [23:0] m, rem, hw;
    logic [4:0]  sh;
    logic [15:0] r;
    logic [15:0] res;
    a = u[30:0];
    e = a[30:23];
    m = {1'b1, a[22:0]};
    sh = 5'(8'd126 - e);
    r = '0; rem = '0; hw = '0;
    if (a > 31'h7F80_0000) begin
      res = 16'h7E00;
    end else if (a >= 31'h477F_F000) begin
      res = {u[31], 15'h7C00};
    end else if (a < 31'h3880_0000) begin
      if (e < 8'd102) begin
        res = {u[31], 15'b0};
      end else begin
        r   = 16'(m >> sh);
        rem = m & ((24'd1 << sh) - 24'd1);
        hw  = 24'd1 << (sh - 5'd1);
        if (rem > hw || (rem == hw && r[0])) r = r + 16'd1;
        res = {u[31], r[14:0]};
      end
    end else begin
      r   = {1'b0, 5'(e - 8'd112), a[22:13]};
      rem = {11'b0, a[12:0]};
      if (rem > 24'h1000 || (rem == 24'h1000 && r[0])) r = r + 16'd1;
      res = {u[31], r[14:0]};
    end
    return res;
  endfunction

  function automatic logic [15:0] f32_to_bf16(logic [31:0] u);
    logic [32:0] t;
    t = {1'b0, u} + 33'h7FFF + 33'(u[16]);
    return (u[30:0] > 31'h7F80_0000) ? 16'h7FC0 : t[31:16];
  endfunction

  function automatic logic [31:0] encode_value(logic [31:0] u, logic [1:0] fmt);
    logic [31:0] r;
    case (fmt)
      FmtFp16: r = {16'b0, f32_to_half(u)};
      FmtBf16: r = {16'b0, f32_to_bf16(u)};
      default: r = (u[30:0] > 31'h7F80_0000) ? 32'h7FC0_0000 : u;
    endcase
    return r;
  endfunction

endpackage

[sv/qdd_fifo.sv]
// Short operation queue between the byte parser and the float engine.
`timescale 1ns / 1ps
`include "quant_block_dequant_dot_unit_defines.svh"
module qdd_fifo
  import qdd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  op_o,
  output logic empty_o
);

  localparam int PtrW = $clog2(QueueDepth);

  op_t             buf_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = cnt_q == (PtrW + 1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign op_o    = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wr_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  `QDD_ASSERT_IMP(a_no_overflow, push_i, !full_o, "push into full queue")
  `QDD_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "pop from empty queue")
  `QDD_ASSERT_NXT(a_push_fills, push_i && !pop_i, !empty_o, "queue empty after push")

endmodule

[sv/qdd_front.sv]
// Byte parser: tracks block layout, holds the scale and nibbles, issues ops.
`timescale 1ns / 1ps
module qdd_front
  import qdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        action_i,
  input  logic [11:0] column_i,
  input  logic [31:0] act_bits_i,
  input  logic [7:0]  weight_byte_i,
  input  logic        quant_type_i,
  input  logic        mode_i,
  input  logic [7:0]  row_blocks_i,
  input  logic        restart_i,
  input  logic        full_i,
  output logic        push_o,
  output op_t         op_o
);

  typedef enum logic [1:0] {F_IDLE, F_HIGH, F_SUM} fstate_e;

  fstate_e     st_q;
  logic [5:0]  pos_q;
  logic [6:0]  bc_q, hb_q;
  logic [15:0] scale_q;
  logic [3:0]  k_q;
  logic        rowend_q;
  logic [7:0]  nib_q [16];

  logic       take, blk_end, row_end_now;
  logic [5:0] pm2;

  assign ready_o     = (st_q == F_IDLE) && !full_i;
  assign take        = valid_i && ready_o;
  assign blk_end     = pos_q == (quant_type_i ? 6'd33 : 6'd17);
  assign row_end_now = blk_end && (({1'b0, bc_q} + 8'd1) >= row_blocks_i);
  assign pm2         = pos_q - 6'd2;

  always_comb begin
    push_o       = 1'b0;
    op_o         = '0;
    op_o.kind    = OP_WEIGHT;
    op_o.scale   = scale_q;
    op_o.emit    = mode_i;
    case (st_q)
      F_IDLE: begin
        if (take && action_i == ActStore) begin
          push_o    = 1'b1;
          op_o.kind = OP_ACT;
          op_o.col  = ColW'(column_i);
          op_o.data = act_bits_i;
        end else if (take && pos_q >= 6'd2) begin
          push_o = 1'b1;
          if (quant_type_i) begin
            op_o.q   = weight_byte_i;
            op_o.col = ColW'({bc_q, pm2[4:0]});
          end else begin
            op_o.q   = 8'(weight_byte_i[3:0]) - 8'd8;
            op_o.col = ColW'({bc_q, 1'b0, pm2[3:0]});
          end
          // A four-bit block's last byte still owes its high nibbles.
          if (quant_type_i || !blk_end) begin
            op_o.last   = mode_i;
            op_o.rowend = mode_i && row_end_now;
          end
        end
      end
      F_HIGH: begin
        push_o   = !full_i;
        op_o.q   = 8'(nib_q[k_q][7:4]) - 8'd8;
        op_o.col = ColW'({hb_q, 1'b1, k_q});
        if (k_q == 4'd15) begin
          op_o.last   = mode_i;
          op_o.rowend = mode_i && rowend_q;
        end
      end
      F_SUM: begin
        push_o      = !full_i;
        op_o.kind   = OP_SUM;
        op_o.last   = 1'b1;
        op_o.rowend = 1'b1;
      end
      default: push_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take && action_i != ActStore && !quant_type_i && pos_q >= 6'd2) begin
      nib_q[pm2[3:0]] <= weight_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= F_IDLE;
      pos_q    <= '0;
      bc_q     <= '0;
      hb_q     <= '0;
      scale_q  <= '0;
      k_q      <= '0;
      rowend_q <= 1'b0;
    end else if (restart_i) begin
      st_q  <= F_IDLE;
      pos_q <= '0;
      bc_q  <= '0;
    end else begin
      case (st_q)
        F_IDLE: begin
          if (take && action_i != ActStore) begin
            if (pos_q == 6'd0) scale_q[7:0]  <= weight_byte_i;
            if (pos_q == 6'd1) scale_q[15:8] <= weight_byte_i;
            if (blk_end) begin
              pos_q <= '0;
              bc_q  <= row_end_now ? 7'd0 : bc_q + 7'd1;
              if (!quant_type_i) begin
                st_q     <= F_HIGH;
                k_q      <= '0;
                hb_q     <= bc_q;
                rowend_q <= row_end_now;
              end else if (row_end_now && !mode_i) begin
                st_q <= F_SUM;
              end
            end else begin
              pos_q <= pos_q + 6'd1;
            end
          end
        end
        F_HIGH: begin
          if (!full_i) begin
            if (k_q == 4'd15) st_q <= (rowend_q && !mode_i) ? F_SUM : F_IDLE;
            k_q <= k_q + 4'd1;
          end
        end
        F_SUM: begin
          if (!full_i) st_q <= F_IDLE;
        end
        default: st_q <= F_IDLE;
      endcase
    end
  end

endmodule

[sv/qdd_back.sv]
// Float engine: activation store, shared multiply/add/round sequence, output register.
`timescale 1ns / 1ps
module qdd_back
  import qdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  op_t         op_i,
  output logic        pop_o,
  input  logic [1:0]  value_format_i,
  input  logic        acc_clr_i,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tuser
);

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_ADD, B_NORM, B_RND, B_ENC} bstate_e;
  typedef enum logic [1:0] {PH_W, PH_P, PH_A} phase_e;

  bstate_e     st_q;
  phase_e      ph_q;
  logic        emit_q, last_q, rowend_q;
  logic [31:0] opa_q, opb_q, acc_q, acc_d, val_q, rd_q;
  pre_t        pre_q, nrm_q;
  logic [31:0] act_mem_q [MaxCols];
  logic [31:0] res;

  assign pop_o = (st_q == B_IDLE) && !empty_i;
  assign res   = fp_round(nrm_q);

  // Accumulator: cleared by a row sum or a restart, loaded after each add.
  always_comb begin
    acc_d = acc_q;
    if (pop_o && op_i.kind == OP_SUM) acc_d = '0;
    if (st_q == B_RND && ph_q == PH_A) acc_d = res;
    if (acc_clr_i) acc_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (op_i.kind == OP_ACT) act_mem_q[op_i.col] <= op_i.data;
      rd_q <= act_mem_q[op_i.col];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= B_IDLE;
      ph_q          <= PH_W;
      emit_q        <= 1'b0;
      last_q        <= 1'b0;
      rowend_q      <= 1'b0;
      opa_q         <= '0;
      opb_q         <= '0;
      acc_q         <= '0;
      val_q         <= '0;
      pre_q         <= '0;
      nrm_q         <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tlast  <= 1'b0;
      m_axis_tuser  <= 1'b0;
    end else begin
      acc_q <= acc_d;
      if (m_axis_tready && st_q != B_ENC) m_axis_tvalid <= 1'b0;
      case (st_q)
        B_IDLE: begin
          if (pop_o) begin
            emit_q   <= op_i.emit;
            last_q   <= op_i.last;
            rowend_q <= op_i.rowend;
            case (op_i.kind)
              OP_WEIGHT: begin
                opa_q <= half_to_f32(op_i.scale);
                opb_q <= i8_to_f32(op_i.q);
                ph_q  <= PH_W;
                st_q  <= B_MUL;
              end
              OP_SUM: begin
                val_q <= acc_q;
                st_q  <= B_ENC;
              end
              default: st_q <= B_IDLE;
            endcase
          end
        end
        B_MUL: begin
          pre_q <= fp_mul_pre(opa_q, opb_q);
          st_q  <= B_NORM;
        end
        B_ADD: begin
          pre_q <= fp_add_pre(opa_q, opb_q);
          st_q  <= B_NORM;
        end
        B_NORM: begin
          nrm_q <= fp_norm(pre_q);
          st_q  <= B_RND;
        end
        B_RND: begin
          case (ph_q)
            PH_W: begin
              if (emit_q) begin
                val_q <= res;
                st_q  <= B_ENC;
              end else begin
                opa_q <= decode_act(rd_q, value_format_i);
                opb_q <= res;
                ph_q  <= PH_P;
                st_q  <= B_MUL;
              end
            end
            PH_P: begin
              opa_q <= acc_q;
              opb_q <= res;
              ph_q  <= PH_A;
              st_q  <= B_ADD;
            end
            default: begin
              st_q <= B_IDLE;
            end
          endcase
        end
        B_ENC: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= encode_value(val_q, value_format_i);
            m_axis_tlast  <= last_q;
            m_axis_tuser  <= rowend_q;
            st_q          <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

endmodule

[sv/quant_block_dequant_dot_unit.sv]
// Top level of the quantized block dequantizer and row dot-product unit.
`timescale 1ns / 1ps
// Streams weight rows made of 32-column blocks (four-bit blocks of 18 bytes or
// eight-bit blocks of 34 bytes, each led by a little-endian fp16 scale) and
// either emits every dequantized weight or, in dot mode, accumulates
// weight * activation in column order in fp32 and emits the row sum on the
// row's last byte. Activations are loaded beforehand by items with action 0.
// An activation item or a scale byte needs no float work. Each weight runs
// through one shared float multiply-or-add, normalize and round sequence: once
// per weight when dequantizing, three times per weight in dot mode (scale times
// value, times activation, plus accumulator, each rounded on its own). The last
// byte of a four-bit block carries 17 weights; the input stays held while its
// 16 high-nibble ops enter the queue. A queue of four ops lets the byte parser
// run ahead of the float engine, and the output register lets the engine
// finish the next result while the previous one waits. A write to any of the
// four config registers restarts the row stream and clears the accumulator.
// The activation store holds whatever was last written; a column never
// written reads as garbage.
module quant_block_dequant_dot_unit
  import qdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // column[11:0], act_bits[43:12], weight_byte[51:44]
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // value_bits[31:0]
  output logic        m_axis_tlast,  // last_in_run
  output logic        m_axis_tuser,  // row_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic       quant_type_q, mode_q;
  logic [7:0] blocks_q, row_blocks;
  logic [1:0] format_q;
  logic       cfg_wr, restart;
  logic       push, pop, full, empty;
  op_t        op_in, op_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  // Only writes to a real register restart the stream.
  assign restart     = cfg_wr && (cfg_index_i <= CfgFormat);

  // Clamp row length to 1..128 blocks.
  assign row_blocks = (blocks_q == 8'd0) ? 8'd1 : (blocks_q > 8'd128) ? 8'd128 : blocks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_type_q <= 1'b0;
      mode_q       <= 1'b0;
      blocks_q     <= 8'd1;
      format_q     <= 2'd0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CfgQuantType: quant_type_q <= cfg_data_i[0];
        CfgMode:      mode_q       <= cfg_data_i[0];
        CfgBlocks:    blocks_q     <= cfg_data_i;
        CfgFormat:    format_q     <= cfg_data_i[1:0];
        default:      blocks_q     <= blocks_q;
      endcase
    end
  end

  qdd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .action_i      (s_axis_tuser),
    .column_i      (s_axis_tdata[11:0]),
    .act_bits_i    (s_axis_tdata[43:12]),
    .weight_byte_i (s_axis_tdata[51:44]),
    .quant_type_i  (quant_type_q),
    .mode_i        (mode_q),
    .row_blocks_i  (row_blocks),
    .restart_i     (restart),
    .full_i        (full),
    .push_o        (push),
    .op_o          (op_in)
  );

  qdd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_in),
    .full_o  (full),
    .pop_i   (pop),
    .op_o    (op_out),
    .empty_o (empty)
  );

  qdd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .op_i           (op_out),
    .pop_o          (pop),
    .value_format_i (format_q),
    .acc_clr_i      (restart),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .m_axis_tuser   (m_axis_tuser)
  );

endmodule
